// File: rtl/core/spiking_cell_potential_sequencer_unit_macros.svh
// Assertion macros for the spiking cell potential sequencer checker.
// Needs nothing else; include by bare file name.
`ifndef SPIKING_CELL_POTENTIAL_SEQUENCER_UNIT_MACROS_SVH
`define SPIKING_CELL_POTENTIAL_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SCSU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("scsu check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low.
`define SCSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("scsu check failed: next-cycle implication");

`endif

// File: rtl/core/scsu_pkg.sv
// Shared types, widths, codes and reset values of the spiking cell sequencer.
// No dependencies.
`default_nettype none

package scsu_pkg;

  localparam int unsigned POT_W         = 20;  // signed Q4.16 potential
  localparam int unsigned LVL_W         = 19;  // unsigned levels and gain
  localparam int unsigned OP_W          = 3;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 20;
  localparam int unsigned QUOT_W        = POT_W;  // quotient bits kept
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam logic signed [POT_W-1:0] POT_MAX = 20'sh7FFFF;
  localparam logic signed [POT_W-1:0] POT_MIN = 20'sh80000;

  // Opcodes
  localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
  localparam logic [OP_W-1:0] OP_ACTIVATE = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD      = 3'd2;
  localparam logic [OP_W-1:0] OP_SET      = 3'd3;
  localparam logic [OP_W-1:0] OP_CHECK    = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REFR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd3;

  localparam logic [LVL_W-1:0]        HOLD_RST   = 19'd13107;
  localparam logic [LVL_W-1:0]        ACTION_RST = 19'd65536;
  localparam logic signed [POT_W-1:0] REFR_RST   = -20'sd26214;
  localparam logic [LVL_W-1:0]        GAIN_RST   = 19'd52429;

  typedef struct packed {
    logic [LVL_W-1:0]        hold;
    logic [LVL_W-1:0]        action;
    logic signed [POT_W-1:0] refr;
    logic [LVL_W-1:0]        gain;
  } cfg_t;

  typedef struct packed {
    logic              done;  // one-cycle pulse when the quotient is ready
    logic              ovf;   // quotient does not fit in QUOT_W bits
    logic [QUOT_W-1:0] quot;
  } div_res_t;

endpackage

`default_nettype wire

// File: rtl/core/scsu_cfg.sv
// Configuration register file of the spiking cell sequencer.
// Depends on scsu_pkg.
`default_nettype none

module scsu_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [scsu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [scsu_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output scsu_pkg::cfg_t                       cfg_o
);
  import scsu_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold   <= HOLD_RST;
      cfg_q.action <= ACTION_RST;
      cfg_q.refr   <= REFR_RST;
      cfg_q.gain   <= GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_HOLD:   cfg_q.hold   <= cfg_data_i[LVL_W-1:0];
        CFG_ACTION: cfg_q.action <= cfg_data_i[LVL_W-1:0];
        CFG_REFR:   cfg_q.refr   <= $signed(cfg_data_i[POT_W-1:0]);
        CFG_GAIN:   cfg_q.gain   <= cfg_data_i[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/core/scsu_div.sv
// Radix-2 restoring divider: (gain << FRAC_BITS) / divisor, one bit a cycle.
// Depends on scsu_pkg. Quotients too wide for QUOT_W bits raise ovf.
`default_nettype none

module scsu_div #(
  parameter int unsigned FRAC_BITS = scsu_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [scsu_pkg::LVL_W-1:0]  gain_i,
  input  wire logic [scsu_pkg::POT_W-1:0]  divisor_i,
  output scsu_pkg::div_res_t               res_o
);
  import scsu_pkg::*;

  localparam int unsigned DV_W  = POT_W;
  localparam int unsigned DVD_W = LVL_W + FRAC_BITS;
  localparam int unsigned HI_W  = DVD_W - QUOT_W;
  localparam int unsigned CMP_W = (HI_W > DV_W) ? HI_W : DV_W;
  localparam int unsigned CNT_W = $clog2(QUOT_W);

  logic [DVD_W-1:0]  dvd;
  logic [CMP_W-1:0]  hi_ext;
  logic              ovf_start;
  logic [DV_W:0]     trial;
  logic [DV_W:0]     diff;
  logic              ge;

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DV_W-1:0]   rem_q, dsr_q;
  logic [QUOT_W-1:0] lo_q, quot_q;
  logic              ovf_q;

  assign dvd       = {gain_i, {FRAC_BITS{1'b0}}};
  assign hi_ext    = CMP_W'(dvd[DVD_W-1 -: HI_W]);
  // The quotient needs more than QUOT_W bits exactly when the top part
  // of the dividend already reaches the divisor.
  assign ovf_start = hi_ext >= CMP_W'(divisor_i);

  assign trial = {rem_q, lo_q[QUOT_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QUOT_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ovf_q  <= ovf_start;
      rem_q  <= ovf_start ? '0 : hi_ext[DV_W-1:0];
      dsr_q  <= divisor_i;
      lo_q   <= dvd[QUOT_W-1:0];
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[DV_W-1:0] : trial[DV_W-1:0];
      lo_q   <= {lo_q[QUOT_W-2:0], 1'b0};
      quot_q <= {quot_q[QUOT_W-2:0], ge};
    end
  end

  assign res_o = '{done: done_q, ovf: ovf_q, quot: quot_q};

endmodule

`default_nettype wire

// File: rtl/core/spiking_cell_potential_sequencer_unit.sv
// Spiking cell potential sequencer: one neuron cell with a Q4.16 potential.
// Depends on scsu_pkg, scsu_cfg and scsu_div.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries opcode_i and value_i;
//   output channel (out_valid_o / out_ready_i) carries one result item per
//   input item: the potential after the item and four status flags.
//   Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_data_i);
//   the user must write it only while the cell is idle; nothing enforces it.
// Latency and throughput:
//   A tick in the rising phase whose gap to the action level exceeds the
//   epsilon runs the radix-2 divider, one quotient bit a cycle over
//   QUOT_W (20) bits; the result is committed from the finishing state. Every
//   other item shows its result the cycle after acceptance. One item is
//   in flight at a time, so the divider loop sets the worst-case rate.
// Reset:
//   rst_ni low clears the potential to rest, the phase to idle, the
//   registers to their defaults and drops any pending result.
// Stall:
//   The result register holds its item until out_ready_i; a new item is
//   taken in the same cycle that the waiting one leaves, never earlier.
`default_nettype none

module spiking_cell_potential_sequencer_unit #(
  parameter int unsigned FRAC_BITS = scsu_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [scsu_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [scsu_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [scsu_pkg::OP_W-1:0]          opcode_i,
  input  wire logic signed [scsu_pkg::POT_W-1:0]  value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [scsu_pkg::POT_W-1:0]       potential_out_o,
  output logic                                    fired_o,
  output logic                                    is_active_o,
  output logic                                    on_update_o,
  output logic                                    under_pressure_o
);
  import scsu_pkg::*;

  // Working width for sums and compares: room for action minus potential
  // plus a full quotient without wrap.
  localparam int unsigned EXT_W = POT_W + 3;
  localparam int unsigned EPS   = ((1 << FRAC_BITS) + 5000) / 10000;

  localparam logic signed [EXT_W-1:0] EPS_X     = EXT_W'(EPS);
  localparam logic signed [EXT_W-1:0] POT_MAX_X = EXT_W'(POT_MAX);
  localparam logic signed [EXT_W-1:0] POT_MIN_X = EXT_W'(POT_MIN);

  // Phases of the cell
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_RISE = 3'd1;
  localparam logic [2:0] PH_REFR = 3'd2;
  localparam logic [2:0] PH_DOWN = 3'd3;
  localparam logic [2:0] PH_UP   = 3'd4;

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  function automatic logic signed [POT_W-1:0] sat_pot(input logic signed [EXT_W-1:0] v);
    logic signed [POT_W-1:0] r;
    if (v > POT_MAX_X) begin
      r = POT_MAX;
    end else if (v < POT_MIN_X) begin
      r = POT_MIN;
    end else begin
      r = $signed(v[POT_W-1:0]);
    end
    return r;
  endfunction

  cfg_t     cfg;
  div_res_t div_res;

  logic [1:0]              st_q, st_d;
  logic signed [POT_W-1:0] pot_q;
  logic [2:0]              ph_q;

  logic                    out_valid_q;
  logic signed [POT_W-1:0] out_pot_q;
  logic                    fired_q, active_q, update_q, press_q;

  logic signed [EXT_W-1:0] pot_x, neg_x, hold_x, action_x, sub_x, quot_x;
  logic signed [POT_W-1:0] rise_base, refr_p, quarter_p, nxt_p;
  logic [2:0]              nxt_ph;
  logic [OP_W-1:0]         op_eff;
  logic                    fin, out_free, accept, need_div, start_div, commit;
  logic                    nxt_fired;

  scsu_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign pot_x    = EXT_W'(pot_q);
  assign neg_x    = -pot_x;
  assign hold_x   = $signed(EXT_W'(cfg.hold));
  assign action_x = $signed(EXT_W'(cfg.action));
  assign sub_x    = action_x - pot_x;
  assign quot_x   = $signed(EXT_W'(div_res.quot));

  // Handshake: take an item only when idle and the result slot frees.
  assign fin        = (st_q == ST_FIN);
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (st_q == ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign need_div   = sub_x > EPS_X;
  assign start_div  = accept && (opcode_i == OP_TICK) && (ph_q == PH_RISE) && need_div;
  assign commit     = (accept && !start_div) || (fin && out_free);

  scsu_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_div),
    .gain_i    (cfg.gain),
    .divisor_i (sub_x[POT_W-1:0]),
    .res_o     (div_res)
  );

  // Step logic. In the finishing state the opcode is the pending rise tick.
  assign op_eff = fin ? OP_TICK : opcode_i;

  always_comb begin
    if (fin) begin
      rise_base = div_res.ovf ? POT_MAX : sat_pot(pot_x + quot_x);
    end else begin
      rise_base = pot_q;
    end
    refr_p    = sat_pot(pot_x + (neg_x >>> 1));
    quarter_p = sat_pot(pot_x + (neg_x >>> 2));

    nxt_p = pot_q;
    nxt_ph = ph_q;
    case (op_eff)
      OP_TICK: begin
        unique case (ph_q)
          PH_IDLE: ;
          PH_RISE: begin
            nxt_p = rise_base;
            if (EXT_W'(rise_base) >= action_x - EPS_X) begin
              nxt_p  = $signed({1'b0, cfg.action});
              nxt_ph = PH_REFR;
            end
          end
          PH_REFR: begin
            nxt_p = refr_p;
            if (EXT_W'(refr_p) < hold_x) begin
              nxt_p  = cfg.refr;
              nxt_ph = PH_UP;
            end
          end
          PH_DOWN: begin
            nxt_p = quarter_p;
            if (EXT_W'(quarter_p) <= EPS_X) begin
              nxt_p  = '0;
              nxt_ph = PH_IDLE;
            end
          end
          PH_UP: begin
            nxt_p = quarter_p;
            if (EXT_W'(quarter_p) >= -EPS_X) begin
              nxt_p  = '0;
              nxt_ph = PH_IDLE;
            end
          end
          default: nxt_ph = PH_IDLE;
        endcase
      end
      OP_ACTIVATE: begin
        if (pot_x < hold_x) begin
          nxt_p  = $signed({1'b0, cfg.hold});
          nxt_ph = PH_RISE;
        end
      end
      OP_ADD: nxt_p = sat_pot(pot_x + EXT_W'(value_i));
      OP_SET: nxt_p = value_i;
      OP_CHECK: begin
        if (pot_x >= hold_x) begin
          nxt_p  = $signed({1'b0, cfg.hold});
          nxt_ph = PH_RISE;
        end else if (pot_q > 0) begin
          nxt_ph = PH_DOWN;
        end else begin
          nxt_ph = PH_UP;
        end
      end
      default: ;  // unused opcodes leave the cell as it is
    endcase

    nxt_fired = (op_eff == OP_TICK) && (EXT_W'(nxt_p) >= hold_x);
  end

  // Sequencer: wait for the divider, then finish the rise step.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (start_div) st_d = ST_DIV;
      ST_DIV:  if (div_res.done) st_d = ST_FIN;
      ST_FIN:  if (out_free) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      pot_q       <= '0;
      ph_q        <= PH_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (commit) begin
        pot_q       <= nxt_p;
        ph_q        <= nxt_ph;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: load on commit, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_pot_q <= nxt_p;
      fired_q   <= nxt_fired;
      active_q  <= EXT_W'(nxt_p) >= hold_x;
      update_q  <= nxt_ph != PH_IDLE;
      press_q   <= nxt_ph == PH_DOWN;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign potential_out_o  = out_pot_q;
  assign fired_o          = fired_q;
  assign is_active_o      = active_q;
  assign on_update_o      = update_q;
  assign under_pressure_o = press_q;

endmodule

`default_nettype wire

// File: rtl/core/scsu_checker.sv
// Port-level checks of the spiking cell sequencer, bound to the top level.
// Depends on scsu_pkg and the macros header.
`default_nettype none
`include "spiking_cell_potential_sequencer_unit_macros.svh"

module scsu_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               cfg_we_i,
  input wire logic [scsu_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input wire logic [scsu_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input wire logic                               in_valid_i,
  input wire logic                               in_ready_o,
  input wire logic [scsu_pkg::OP_W-1:0]          opcode_i,
  input wire logic signed [scsu_pkg::POT_W-1:0]  value_i,
  input wire logic                               out_valid_o,
  input wire logic                               out_ready_i,
  input wire logic signed [scsu_pkg::POT_W-1:0]  potential_out_o,
  input wire logic                               fired_o,
  input wire logic                               is_active_o,
  input wire logic                               on_update_o,
  input wire logic                               under_pressure_o
);
  import scsu_pkg::*;

  logic [OP_W-1:0]         last_op_q;
  logic signed [POT_W-1:0] last_val_q;
  logic                    cfg_seen;

  assign cfg_seen = cfg_we_i && (cfg_index_i == CFG_HOLD) && (cfg_data_i == cfg_data_i);

  // Track the last accepted item: the shown result always belongs to it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_op_q  <= OP_CHECK;
      last_val_q <= '0;
    end else if (in_valid_i && in_ready_o) begin
      last_op_q  <= opcode_i;
      last_val_q <= value_i;
    end
  end

  `SCSU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i && !cfg_seen, out_valid_o)
  `SCSU_ASSERT_IMPL(a_fired_tick, clk_i, rst_ni, out_valid_o && fired_o, last_op_q == OP_TICK)
  `SCSU_ASSERT_IMPL(a_fired_active, clk_i, rst_ni, out_valid_o && fired_o, is_active_o)
  `SCSU_ASSERT_IMPL(a_set_value, clk_i, rst_ni, out_valid_o && (last_op_q == OP_SET), potential_out_o == last_val_q)
  `SCSU_ASSERT_IMPL(a_press_update, clk_i, rst_ni, out_valid_o && under_pressure_o, on_update_o)

endmodule

bind spiking_cell_potential_sequencer_unit scsu_checker u_scsu_checker (.*);

`default_nettype wire
